FILE: hdl/tswc_pkg.sv
`timescale 1ns / 1ps

package tswc_pkg;

    localparam logic [1:0] FUNC_RX_SEG   = 2'd0;
    localparam logic [1:0] FUNC_SEND     = 2'd1;
    localparam logic [1:0] FUNC_TAKEOVER = 2'd2;

    localparam logic [1:0] PHASE_NONE    = 2'd0;
    localparam logic [1:0] PHASE_NEW     = 2'd1;
    localparam logic [1:0] PHASE_RUNNING = 2'd2;
    localparam logic [1:0] PHASE_DONE    = 2'd3;

    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_DROP  = 2'd1;
    localparam logic [1:0] VERDICT_TX    = 2'd2;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 1'd1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd2000000000;
    localparam logic [7:0]  DUP_ACK_MAX   = 8'hff;

    typedef struct packed {
        logic [1:0]  func;
        logic        flow_match;
        logic [31:0] ack_number;
        logic [31:0] peer_seq;
        logic [15:0] peer_window;
        logic        syn_flag;
        logic        fin_flag;
        logic        rst_flag;
        logic [15:0] segment_len;
        logic [31:0] pkt_seq;
        logic [15:0] pkt_checksum;
        logic [63:0] now_ns;
    } item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] out_seq;
        logic [15:0] out_checksum;
        logic        resent;
        logic [31:0] retransmit_total;
        logic [31:0] peer_next_seq;
    } result_t;

    typedef struct packed {
        logic [3:0]  window_scale;
        logic [31:0] timeout_ns;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] send_seq;
        logic [31:0] highest_sent;
        logic [31:0] last_ack;
        logic [15:0] peer_window;
        logic [31:0] peer_seq;
        logic [7:0]  dup_ack_count;
        logic [63:0] last_progress_ns;
        logic [31:0] retransmits;
    } flow_t;

    // serial-number compare: a is before b
    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        begin
            d = a - b;
            return d[31];
        end
    endfunction

    // incremental checksum update for a 32-bit field change
    function automatic logic [15:0] patch_checksum(input logic [15:0] ck,
                                                   input logic [31:0] old_seq,
                                                   input logic [31:0] new_seq);
        logic [18:0] s;
        logic [16:0] f1;
        logic [15:0] f2;
        begin
            s = {3'd0, ~ck} + {3'd0, ~old_seq[31:16]} + {3'd0, ~old_seq[15:0]}
              + {3'd0, new_seq[31:16]} + {3'd0, new_seq[15:0]};
            f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
            f2 = f1[15:0] + {15'd0, f1[16]};
            return ~f2;
        end
    endfunction

endpackage

FILE: hdl/tswc_engine.sv
`timescale 1ns / 1ps

module tswc_engine
(
    input  tswc_pkg::flow_t   flow,
    input  tswc_pkg::cfg_t    cfg,
    input  tswc_pkg::item_t   item,
    output tswc_pkg::flow_t   flow_next,
    output tswc_pkg::result_t res
);

    always_comb
    begin
        tswc_pkg::flow_t f;
        logic        rewind;
        logic [63:0] idle_ns;
        logic [31:0] nseq;
        logic [31:0] win;
        logic [31:0] seq_end;
        logic [31:0] win_end;

        f = flow;
        res = '0;
        res.verdict = tswc_pkg::VERDICT_PASS;
        idle_ns = item.now_ns - flow.last_progress_ns;
        rewind = (flow.dup_ack_count != 8'd0)
              || ((flow.last_progress_ns != 64'd0) && (idle_ns > {32'd0, cfg.timeout_ns}));
        nseq = rewind ? flow.last_ack : flow.send_seq;
        win = {16'd0, flow.peer_window} << cfg.window_scale;
        seq_end = nseq + {16'd0, item.segment_len};
        win_end = flow.last_ack + win;

        case (item.func)
            tswc_pkg::FUNC_RX_SEG:
            begin
                if (item.flow_match)
                begin
                    if (flow.phase == tswc_pkg::PHASE_NONE)
                    begin
                        f = '0;
                        f.phase = tswc_pkg::PHASE_NEW;
                        f.send_seq = item.ack_number;
                    end
                    if ((f.last_ack == item.ack_number) && (f.dup_ack_count != tswc_pkg::DUP_ACK_MAX))
                        f.dup_ack_count = f.dup_ack_count + 8'd1;
                    f.peer_window = item.peer_window;
                    f.last_ack = item.ack_number;
                    f.peer_seq = item.syn_flag ? item.peer_seq + 32'd1 : item.peer_seq;
                    if (item.fin_flag || item.rst_flag)
                        f.phase = tswc_pkg::PHASE_DONE;
                    if (f.phase == tswc_pkg::PHASE_RUNNING || f.phase == tswc_pkg::PHASE_DONE)
                        res.verdict = tswc_pkg::VERDICT_DROP;
                end
            end
            tswc_pkg::FUNC_SEND:
            begin
                if (flow.phase != tswc_pkg::PHASE_RUNNING)
                begin
                    res.verdict = tswc_pkg::VERDICT_DROP;
                end
                else
                begin
                    if (rewind)
                        f.dup_ack_count = 8'd0;
                    f.send_seq = nseq;
                    if (!tswc_pkg::seq_before(seq_end, win_end))
                    begin
                        res.verdict = tswc_pkg::VERDICT_DROP;
                    end
                    else
                    begin
                        if (!tswc_pkg::seq_before(nseq, flow.highest_sent))
                        begin
                            f.highest_sent = nseq;
                        end
                        else
                        begin
                            res.resent = 1'b1;
                            f.retransmits = flow.retransmits + 32'd1;
                        end
                        f.send_seq = seq_end;
                        f.last_progress_ns = item.now_ns;
                        res.verdict = tswc_pkg::VERDICT_TX;
                        res.out_seq = nseq;
                        res.out_checksum = (nseq != item.pkt_seq)
                            ? tswc_pkg::patch_checksum(item.pkt_checksum, item.pkt_seq, nseq)
                            : item.pkt_checksum;
                    end
                end
            end
            tswc_pkg::FUNC_TAKEOVER:
            begin
                if (flow.phase != tswc_pkg::PHASE_NONE)
                    f.phase = tswc_pkg::PHASE_RUNNING;
            end
            default:
            begin
                f = flow;
            end
        endcase

        res.retransmit_total = f.retransmits;
        res.peer_next_seq = f.peer_seq;
        flow_next = f;
    end

endmodule

FILE: hdl/tcp_sender_window_control.sv
`timescale 1ns / 1ps

// Single-flow TCP sender window control. One item per clock sustained while out_stall
// is low. An accepted item sits in the input register, and its result is then held in
// the result register until the receiver takes it. Flow state is updated as an item
// moves from the input register into the result register, so the next item always
// sees it. The longest path is the 64-bit idle-time compare feeding the sequence
// rewind and window check. Configuration writes are always ready and take effect at once.
module tcp_sender_window_control
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  tswc_pkg::item_t                      in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output tswc_pkg::result_t                    out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tswc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);

    logic              item_valid_reg;
    tswc_pkg::item_t   item_reg;
    logic              out_valid_reg;
    tswc_pkg::result_t out_data_reg;
    tswc_pkg::flow_t   flow_reg;
    tswc_pkg::flow_t   flow_next;
    tswc_pkg::cfg_t    cfg_reg;
    tswc_pkg::result_t res_next;
    logic              advance;

    assign advance   = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    tswc_engine u_engine
    (
        .flow      (flow_reg),
        .cfg       (cfg_reg),
        .item      (item_reg),
        .flow_next (flow_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            flow_reg       <= '0;
            cfg_reg.window_scale <= 4'd0;
            cfg_reg.timeout_ns   <= tswc_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (!in_stall)
                item_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flow_reg      <= flow_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    tswc_pkg::CFG_WINDOW_SCALE: cfg_reg.window_scale <= cfg_data[3:0];
                    tswc_pkg::CFG_TIMEOUT:      cfg_reg.timeout_ns   <= cfg_data;
                    default:                    cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            item_reg <= in_data;
        if (advance)
            out_data_reg <= res_next;
    end

    // non-transmit results carry no sequence, checksum or resend mark
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.verdict != tswc_pkg::VERDICT_TX)
        |-> (out_data.out_seq == 32'd0) && (out_data.out_checksum == 16'd0)
            && !out_data.resent)
        else $error("non-transmit result carries packet fields");

    // input side only stalls on a held item
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked item");

    // a resend bumps the running count by one
    a_resend_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.resent |-> res_next.retransmit_total == flow_reg.retransmits + 32'd1)
        else $error("retransmit count out of step");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.verdict == tswc_pkg::VERDICT_PASS)
                   || (out_data.verdict == tswc_pkg::VERDICT_DROP)
                   || (out_data.verdict == tswc_pkg::VERDICT_TX))
        else $error("unused verdict code");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    // {syn, fin, rst}
    localparam logic [2:0]  FLG_NONE     = 3'b000;
    localparam logic [2:0]  FLG_SYN      = 3'b100;
    localparam logic [2:0]  FLG_FIN      = 3'b010;
    localparam logic [2:0]  FLG_RST      = 3'b001;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    tswc_pkg::item_t                in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    tswc_pkg::result_t              out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tswc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                    cfg_data  = '0;

    tcp_sender_window_control u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sender-side view of the flow, kept in step with accepted items
    logic [3:0]  win_shift;
    logic [31:0] idle_limit;
    logic [1:0]  phase;
    logic [31:0] snd_nxt;
    logic [31:0] snd_max;
    logic [31:0] acked;
    logic [15:0] rwnd;
    logic [31:0] rcv_nxt;
    logic [7:0]  dupacks;
    logic [63:0] progress_ns;
    logic [31:0] rexmits;

    tswc_pkg::result_t verdicts_due[$];
    logic [63:0] clock_ns    = 64'd1000;
    bit          in_gaps_on  = 1'b1;
    bit          out_gaps_on = 1'b1;
    int unsigned hold_req    = 0;
    int unsigned hold_left   = 0;
    int unsigned stall_left  = 0;
    int unsigned mismatches  = 0;
    int unsigned cycles      = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void clear_flow_state();
        phase       = tswc_pkg::PHASE_NONE;
        snd_nxt     = '0;
        snd_max     = '0;
        acked       = '0;
        rwnd        = '0;
        rcv_nxt     = '0;
        dupacks     = '0;
        progress_ns = '0;
        rexmits     = '0;
    endfunction

    function automatic logic serial_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    // one's-complement update for a 32-bit field rewrite
    function automatic logic [15:0] refold_checksum(input logic [15:0] ck,
                                                    input logic [31:0] was,
                                                    input logic [31:0] now_val);
        logic [15:0] nck;
        logic [15:0] nhi;
        logic [15:0] nlo;
        logic [31:0] acc;
        nck = ~ck;
        nhi = ~was[31:16];
        nlo = ~was[15:0];
        acc = 32'(nck) + 32'(nhi) + 32'(nlo) + 32'(now_val[31:16]) + 32'(now_val[15:0]);
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        return ~acc[15:0];
    endfunction

    function automatic tswc_pkg::result_t compute_verdict(input tswc_pkg::item_t it);
        tswc_pkg::result_t r;
        logic [31:0]       seq0;
        logic [31:0]       span;
        r = '0;
        r.verdict = tswc_pkg::VERDICT_PASS;
        case (it.func)
            tswc_pkg::FUNC_RX_SEG:
            begin
                if (it.flow_match)
                begin
                    if (phase == tswc_pkg::PHASE_NONE)
                    begin
                        clear_flow_state();
                        phase   = tswc_pkg::PHASE_NEW;
                        snd_nxt = it.ack_number;
                    end
                    if (acked == it.ack_number && dupacks != tswc_pkg::DUP_ACK_MAX)
                        dupacks = dupacks + 8'd1;
                    rwnd    = it.peer_window;
                    acked   = it.ack_number;
                    rcv_nxt = it.syn_flag ? it.peer_seq + 32'd1 : it.peer_seq;
                    if (it.fin_flag || it.rst_flag)
                        phase = tswc_pkg::PHASE_DONE;
                    if (phase == tswc_pkg::PHASE_RUNNING || phase == tswc_pkg::PHASE_DONE)
                        r.verdict = tswc_pkg::VERDICT_DROP;
                end
            end
            tswc_pkg::FUNC_SEND:
            begin
                if (phase != tswc_pkg::PHASE_RUNNING)
                    r.verdict = tswc_pkg::VERDICT_DROP;
                else
                begin
                    if (dupacks != 8'd0 ||
                        (progress_ns != 64'd0 &&
                         it.now_ns - progress_ns > {32'd0, idle_limit}))
                    begin
                        snd_nxt = acked;
                        dupacks = '0;
                    end
                    seq0 = snd_nxt;
                    span = {16'd0, rwnd} << win_shift;
                    if (!serial_lt(seq0 + {16'd0, it.segment_len}, acked + span))
                        r.verdict = tswc_pkg::VERDICT_DROP;
                    else
                    begin
                        if (!serial_lt(seq0, snd_max))
                            snd_max = seq0;
                        else
                        begin
                            r.resent = 1'b1;
                            rexmits  = rexmits + 32'd1;
                        end
                        snd_nxt     = seq0 + {16'd0, it.segment_len};
                        progress_ns = it.now_ns;
                        r.verdict   = tswc_pkg::VERDICT_TX;
                        r.out_seq   = seq0;
                        r.out_checksum = (seq0 != it.pkt_seq)
                                       ? refold_checksum(it.pkt_checksum, it.pkt_seq, seq0)
                                       : it.pkt_checksum;
                    end
                end
            end
            tswc_pkg::FUNC_TAKEOVER:
            begin
                if (phase != tswc_pkg::PHASE_NONE)
                    phase = tswc_pkg::PHASE_RUNNING;
            end
            default:
            begin
            end
        endcase
        r.retransmit_total = rexmits;
        r.peer_next_seq    = rcv_nxt;
        return r;
    endfunction

    // receiver: random stall bursts, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall = 1'b1;
        end
        else if (hold_req != 0)
        begin
            hold_left = hold_req - 1;
            hold_req  = 0;
            out_stall = 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall = 1'b1;
        end
        else if (out_gaps_on && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            out_stall  = 1'b1;
        end
        else
            out_stall = 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        tswc_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: verdict=%0d seq=%h ck=%h",
                             out_data.verdict, out_data.out_seq, out_data.out_checksum);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (out_data.verdict !== want.verdict ||
                    out_data.out_seq !== want.out_seq ||
                    out_data.out_checksum !== want.out_checksum ||
                    out_data.resent !== want.resent ||
                    out_data.retransmit_total !== want.retransmit_total ||
                    out_data.peer_next_seq !== want.peer_next_seq)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp: verdict=%0d seq=%h ck=%h resent=%b rtx=%0d peer=%h",
                                 want.verdict, want.out_seq, want.out_checksum,
                                 want.resent, want.retransmit_total, want.peer_next_seq);
                        $display("         got: verdict=%0d seq=%h ck=%h resent=%b rtx=%0d peer=%h",
                                 out_data.verdict, out_data.out_seq, out_data.out_checksum,
                                 out_data.resent, out_data.retransmit_total,
                                 out_data.peer_next_seq);
                    end
                end
            end
        end
    end

    task automatic send_item(input tswc_pkg::item_t it);
        int unsigned gap;
        gap = 0;
        if (in_gaps_on && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, 19);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        verdicts_due.push_back(compute_verdict(it));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [tswc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == tswc_pkg::CFG_WINDOW_SCALE)
            win_shift = val[3:0];
        else
            idle_limit = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [3:0] shift, input logic [31:0] limit);
        drain();
        write_reg(tswc_pkg::CFG_WINDOW_SCALE, {28'd0, shift});
        write_reg(tswc_pkg::CFG_TIMEOUT, limit);
    endtask

    task automatic rx_seg(input logic [31:0] ack, input logic [15:0] wnd,
                          input logic [31:0] pseq, input logic [2:0] flags);
        tswc_pkg::item_t it;
        it = '0;
        it.func        = tswc_pkg::FUNC_RX_SEG;
        it.flow_match  = 1'b1;
        it.ack_number  = ack;
        it.peer_seq    = pseq;
        it.peer_window = wnd;
        {it.syn_flag, it.fin_flag, it.rst_flag} = flags;
        it.now_ns      = clock_ns;
        send_item(it);
    endtask

    task automatic send_req(input logic [15:0] len, input logic [31:0] pseq,
                            input logic [15:0] ck, input logic [63:0] now_val);
        tswc_pkg::item_t it;
        it = '0;
        it.func         = tswc_pkg::FUNC_SEND;
        it.segment_len  = len;
        it.pkt_seq      = pseq;
        it.pkt_checksum = ck;
        it.now_ns       = now_val;
        send_item(it);
    endtask

    task automatic take_over();
        tswc_pkg::item_t it;
        it = '0;
        it.func = tswc_pkg::FUNC_TAKEOVER;
        send_item(it);
    endtask

    function automatic tswc_pkg::item_t gen_item();
        tswc_pkg::item_t it;
        int unsigned     pick;
        int unsigned     sel;
        // background noise in every field, then shape what matters
        it.func         = tswc_pkg::FUNC_RX_SEG;
        it.flow_match   = 1'($urandom);
        it.ack_number   = $urandom;
        it.peer_seq     = $urandom;
        it.peer_window  = 16'($urandom);
        it.syn_flag     = 1'($urandom);
        it.fin_flag     = 1'($urandom);
        it.rst_flag     = 1'($urandom);
        it.segment_len  = 16'($urandom);
        it.pkt_seq      = $urandom;
        it.pkt_checksum = 16'($urandom);
        it.now_ns       = {$urandom, $urandom};

        sel = $urandom_range(0, 99);
        if (sel < 2)
            clock_ns = clock_ns + 64'd2000000000 + 64'($urandom_range(0, 100));
        else if (sel < 7)
            clock_ns = clock_ns + 64'($urandom_range(1000, 50000));
        else
            clock_ns = clock_ns + 64'($urandom_range(1, 3000));

        pick = $urandom_range(0, 99);
        if (phase == tswc_pkg::PHASE_DONE && pick < 50)
            it.func = tswc_pkg::FUNC_TAKEOVER;
        else if (pick < 2)
            it.func = FUNC_UNUSED;
        else if (pick < 5)
            it.func = tswc_pkg::FUNC_TAKEOVER;
        else if (pick < 45)
        begin
            it.func       = tswc_pkg::FUNC_RX_SEG;
            it.flow_match = ($urandom_range(0, 15) != 0);
            sel = $urandom_range(0, 99);
            if (sel < 25)
                it.ack_number = acked;
            else if (sel < 50)
                it.ack_number = snd_nxt;
            else if (sel < 85)
                it.ack_number = acked + $urandom_range(0, 3000);
            if ($urandom_range(0, 9) == 0)
                it.peer_window = '0;
            it.syn_flag = ($urandom_range(0, 3) == 0);
            it.fin_flag = ($urandom_range(0, 49) == 0);
            it.rst_flag = ($urandom_range(0, 49) == 0);
            it.now_ns   = clock_ns;
        end
        else
        begin
            it.func = tswc_pkg::FUNC_SEND;
            if ($urandom_range(0, 9) != 0)
                it.segment_len = 16'($urandom_range(0, 1500));
            if ($urandom_range(0, 9) < 3)
                it.pkt_seq = snd_nxt;
            sel = $urandom_range(0, 99);
            if (sel < 2)
                it.now_ns = '0;
            else if (sel >= 4)
                it.now_ns = clock_ns;
        end
        return it;
    endfunction

    task automatic run_random(input int unsigned count);
        repeat (count)
            send_item(gen_item());
    endtask

    task automatic test_special_cases();
        tswc_pkg::item_t it;
        send_req(16'd100, 32'd0, 16'd0, 64'd10);            // no flow yet
        take_over();                                        // nothing to take over
        it = '1;
        it.func       = tswc_pkg::FUNC_RX_SEG;
        it.flow_match = 1'b0;
        send_item(it);
        it = '1;
        it.func = FUNC_UNUSED;
        send_item(it);
        // flow creation with ack 0 is a dup at once; peer seq wraps with SYN
        rx_seg(32'd0, 16'hffff, 32'hffffffff, FLG_SYN);
        rx_seg(32'd1000, 16'hffff, 32'd5, FLG_NONE);
        send_req(16'd100, 32'd1000, 16'h1234, 64'd100);     // new, not running
        take_over();
        send_req(16'd100, 32'd1000, 16'h1234, 64'd100);     // rewind, seq unchanged
        send_req(16'hffff, 32'd0, 16'hbeef, 64'd200);       // window full
        send_req(16'd0, 32'hffffffff, 16'h0000, 64'd300);
        send_req(16'd50, 32'd0, 16'hffff, 64'd400);
        rx_seg(32'd1000, 16'd0, 32'd77, FLG_NONE);          // dup, zero window
        send_req(16'd10, 32'd0, 16'h5555, 64'd500);         // rewind then full
        rx_seg(32'd1000, 16'hffff, 32'd78, FLG_NONE);
        send_req(16'd10, 32'd0, 16'haaaa, 64'd600);         // retransmit
        send_req(16'd10, 32'h12345678, 16'h0f0f, 64'd600 + 64'd2000000001);
        send_req(16'd10, 32'd1010, 16'h0001, 64'd0);        // zero time stored
        send_req(16'd10, 32'd0, 16'h0002, 64'hffffffffffffffff);
        rx_seg(32'd1020, 16'hffff, 32'd79, FLG_FIN);
        send_req(16'd10, 32'd0, 16'h0003, 64'd700);         // flow done
        take_over();
        rx_seg(32'd1020, 16'hffff, 32'd80, FLG_RST);
        take_over();
    endtask

    // 256 dups must stick at the ceiling, so the next send still rewinds
    task automatic test_dup_saturation();
        send_req(16'd200, 32'd0, 16'h0bad, progress_ns);
        repeat (256)
            rx_seg(acked, 16'hffff, $urandom, FLG_NONE);
        send_req(16'd1, $urandom, 16'($urandom), progress_ns);
    endtask

    task automatic test_scaled_window();
        configure(4'd14, 32'hffffffff);
        run_random(200);
    endtask

    task automatic test_zero_timeout();
        configure(4'd0, 32'd0);
        run_random(200);
    endtask

    task automatic test_short_timeout();
        configure(4'($urandom_range(1, 13)), $urandom_range(1000, 20000));
        run_random(300);
    endtask

    task automatic test_backpressure();
        drain();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        hold_req    = 120;
        run_random(80);
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        configure(4'd7, tswc_pkg::TIMEOUT_RESET);
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        run_random(250);
    endtask

    initial
    begin
        win_shift  = '0;
        idle_limit = tswc_pkg::TIMEOUT_RESET;
        clear_flow_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_dup_saturation();
        test_scaled_window();
        test_zero_timeout();
        test_short_timeout();
        test_backpressure();
        test_steady_stream();

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
